// File: rtl/gpthc_pkg.sv
// Shared types, constants and CRC helper for the GPT header CRC checker.
package gpthc_pkg;

  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
  localparam logic [4:0]  OFFSET_MAX = 5'd31;
  localparam logic [4:0]  CSUM_FIRST = 5'd16;
  localparam logic [4:0]  CSUM_END   = 5'd20;
  localparam logic [4:0]  SIG_LEN    = 5'd8;

  // Depth of the byte queue between front and back ends; a power of two.
  localparam int OPQ_DEPTH = 4;
  localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
  localparam int OPQ_CNT_W = OPQ_PTR_W + 1;

  // Run modes as carried in req_type.
  localparam logic MODE_HEADER = 1'b0;
  localparam logic MODE_ARRAY  = 1'b1;

  // One input transfer.
  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // One result transfer.
  typedef struct packed {
    logic [31:0] crc_value;
    logic        crc_match;
    logic        signature_ok;
    logic        too_short;
  } out_t;

  // Classified byte handed from the front end to the CRC back end.
  typedef struct packed {
    logic [7:0] fed_byte;   // byte as it enters the CRC
    logic [7:0] raw_byte;   // byte as received, for the stored checksum
    logic       csum_en;    // byte belongs to the stored checksum field
    logic [1:0] csum_lane;  // byte lane within the stored checksum
    logic       sig_bad;    // byte breaks the signature
    logic       header;     // run is in header mode
    logic       too_short;  // run would end before the checksum is complete
    logic       sig_long;   // run would cover the whole signature
    logic       last;       // final byte of the run
  } op_t;

  // Signature "EFI PART", one byte per offset.
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h45;
      3'd1:    b = 8'h46;
      3'd2:    b = 8'h49;
      3'd3:    b = 8'h20;
      3'd4:    b = 8'h50;
      3'd5:    b = 8'h41;
      3'd6:    b = 8'h52;
      3'd7:    b = 8'h54;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Reflected CRC-32 update by one byte.
  function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/gpthc_front.sv
// Front end: tracks the byte offset and run mode and classifies each byte.
module gpthc_front import gpthc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  in_t  in_data,
  output logic op_push,
  input  logic op_full,
  output op_t  op_data
);

  logic [4:0] offset_r;
  logic [4:0] offset_nxt;
  logic       mode_r;
  logic       mode_nxt;
  logic       mode_cur;
  logic       header;
  logic       accept;

  assign in_full = op_full;
  assign accept  = in_push && !op_full;
  assign op_push = accept;

  // The mode is sampled on the first byte of a run and held after it.
  assign mode_cur = (offset_r == 5'd0) ? in_data.req_type : mode_r;
  assign header   = (mode_cur == MODE_HEADER);

  // Classify the byte for the back end.
  always_comb begin
    op_data.raw_byte  = in_data.data_byte;
    op_data.csum_en   = header && (offset_r >= CSUM_FIRST) && (offset_r < CSUM_END);
    op_data.csum_lane = offset_r[1:0];
    op_data.fed_byte  = op_data.csum_en ? 8'd0 : in_data.data_byte;
    op_data.sig_bad   = header && (offset_r < SIG_LEN) &&
                        (in_data.data_byte != sig_byte(offset_r[2:0]));
    op_data.header    = header;
    op_data.too_short = header && (offset_r < (CSUM_END - 5'd1));
    op_data.sig_long  = (offset_r >= (SIG_LEN - 5'd1));
    op_data.last      = in_data.last_byte;
  end

  // Offset saturates on long runs and restarts after the last byte.
  always_comb begin
    offset_nxt = offset_r;
    mode_nxt   = mode_r;
    if (accept) begin
      mode_nxt = mode_cur;
      if (in_data.last_byte) begin
        offset_nxt = 5'd0;
        mode_nxt   = MODE_HEADER;
      end else if (offset_r < OFFSET_MAX) begin
        offset_nxt = offset_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= 5'd0;
      mode_r   <= MODE_HEADER;
    end else begin
      offset_r <= offset_nxt;
      mode_r   <= mode_nxt;
    end
  end

endmodule

// File: rtl/gpthc_op_queue.sv
// Four-entry queue of classified bytes between the front and back ends.
module gpthc_op_queue import gpthc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  op_t  push_data,
  output logic empty,
  input  logic pop,
  output op_t  pop_data
);

  op_t                  mem_r [OPQ_DEPTH];
  logic [OPQ_PTR_W-1:0] wr_ptr_r;
  logic [OPQ_PTR_W-1:0] rd_ptr_r;
  logic [OPQ_CNT_W-1:0] count_r;
  logic [OPQ_CNT_W-1:0] count_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign full     = (count_r == OPQ_CNT_W'(OPQ_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + OPQ_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - OPQ_CNT_W'(1);
    end
  end

  // Storage holds payload only.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + OPQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + OPQ_PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

// File: rtl/gpthc_back.sv
// Back end: runs the CRC, gathers the stored checksum and buffers results.
module gpthc_back import gpthc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic op_empty,
  output logic op_pop,
  input  op_t  op_data,
  output logic out_empty,
  input  logic out_pop,
  output out_t out_data
);

  logic [31:0] crc_r;
  logic [31:0] crc_nxt;
  logic [31:0] stored_r;
  logic [31:0] stored_nxt;
  logic        sig_ok_r;
  logic        sig_ok_nxt;
  logic [31:0] crc_upd;
  logic [31:0] stored_upd;
  logic        sig_upd;
  logic [31:0] crc_out;
  out_t        res;

  out_t        res_mem_r [2];
  logic        res_wr_r;
  logic        res_rd_r;
  logic [1:0]  res_count_r;
  logic [1:0]  res_count_nxt;
  logic        res_push;
  logic        res_pop;

  // A byte is taken whenever there is room for a possible result.
  assign op_pop = !op_empty && (res_count_r != 2'd2);

  // Per-byte update of the running state.
  always_comb begin
    crc_upd    = crc_feed(crc_r, op_data.fed_byte);
    stored_upd = stored_r;
    if (op_data.csum_en) begin
      stored_upd = stored_r | ({24'd0, op_data.raw_byte} << {op_data.csum_lane, 3'd0});
    end
    sig_upd = sig_ok_r && !op_data.sig_bad;
    crc_out = crc_upd ^ CRC_INIT;
  end

  // Result of a run, formed on its last byte.
  always_comb begin
    res.crc_value    = crc_out;
    res.crc_match    = op_data.header && !op_data.too_short && (crc_out == stored_upd);
    res.signature_ok = op_data.header && sig_upd && op_data.sig_long;
    res.too_short    = op_data.too_short;
  end

  // Next run state; everything restarts after the last byte.
  always_comb begin
    crc_nxt    = crc_r;
    stored_nxt = stored_r;
    sig_ok_nxt = sig_ok_r;
    if (op_pop) begin
      if (op_data.last) begin
        crc_nxt    = CRC_INIT;
        stored_nxt = 32'd0;
        sig_ok_nxt = 1'b1;
      end else begin
        crc_nxt    = crc_upd;
        stored_nxt = stored_upd;
        sig_ok_nxt = sig_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= CRC_INIT;
      stored_r <= 32'd0;
      sig_ok_r <= 1'b1;
    end else begin
      crc_r    <= crc_nxt;
      stored_r <= stored_nxt;
      sig_ok_r <= sig_ok_nxt;
    end
  end

  // Two-entry result buffer on the output side.
  assign res_push  = op_pop && op_data.last;
  assign out_empty = (res_count_r == 2'd0);
  assign res_pop   = out_pop && !out_empty;
  assign out_data  = res_mem_r[res_rd_r];

  always_comb begin
    res_count_nxt = res_count_r;
    if (res_push && !res_pop) begin
      res_count_nxt = res_count_r + 2'd1;
    end else if (res_pop && !res_push) begin
      res_count_nxt = res_count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem_r[res_wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_r    <= 1'b0;
      res_rd_r    <= 1'b0;
      res_count_r <= 2'd0;
    end else begin
      if (res_push) begin
        res_wr_r <= ~res_wr_r;
      end
      if (res_pop) begin
        res_rd_r <= ~res_rd_r;
      end
      res_count_r <= res_count_nxt;
    end
  end

endmodule

// File: rtl/gpt_header_crc_checker_unit.sv
// GPT header CRC checker: takes one byte per transfer and reports the reflected CRC-32
// (polynomial 0xEDB88320, start all ones, final inversion) of each run on its last
// byte. In header mode, bytes 16 to 19 enter the CRC as zero and form the stored
// checksum, and bytes 0 to 7 are checked against "EFI PART". One byte is accepted
// every cycle while the byte queue has room; the byte-wide CRC update in the back
// end sets that rate. When its last byte is accepted, the front end classifies
// that byte in the same cycle, the byte is written into the four-entry byte queue,
// and as the back end consumes it, the result goes into the two-entry result
// buffer that feeds the output. Input stalls only when both buffers fill.
module gpt_header_crc_checker_unit import gpthc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  in_t  in_data,
  output logic out_empty,
  input  logic out_pop,
  output out_t out_data
);

  logic op_push;
  logic op_full;
  op_t  op_wdata;
  logic op_empty;
  logic op_pop;
  op_t  op_rdata;

  // Byte classification.
  gpthc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .op_push (op_push),
    .op_full (op_full),
    .op_data (op_wdata)
  );

  // Decoupling queue.
  gpthc_op_queue u_op_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (op_push),
    .full      (op_full),
    .push_data (op_wdata),
    .empty     (op_empty),
    .pop       (op_pop),
    .pop_data  (op_rdata)
  );

  // CRC and result generation.
  gpthc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_empty  (op_empty),
    .op_pop    (op_pop),
    .op_data   (op_rdata),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
